FILE: hw/rtl/binary_prefix_trie_table_defines.svh
// Assertion macros for the binary prefix trie table.
// Taken in by the top level; no other dependencies.
`ifndef BINARY_PREFIX_TRIE_TABLE_DEFINES_SVH
`define BINARY_PREFIX_TRIE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define BPTT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bptt: assertion failed");

// Next-cycle implication, disabled while reset is low
`define BPTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bptt: assertion failed");

`endif

FILE: hw/rtl/bptt_pkg.sv
// Shared constants, types and state codes of the binary prefix trie table.
// Used by every module of the block; depends on nothing.
package bptt_pkg;

  localparam int unsigned KEY_BITS   = 13;
  localparam int unsigned ID_W       = 16;
  localparam int unsigned NUM_DEPTHS = KEY_BITS + 1;
  localparam int unsigned LEN_W      = $clog2(KEY_BITS + 1);
  localparam int unsigned KIND_W     = 2;

  // Operation codes on the input channel
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEL    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

  // One node of a depth bank
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
  } entry_t;

  // Classified item travelling from front to back
  typedef struct packed {
    logic                write_en;   // add or delete that touches the store
    logic                set_valid;  // add: mark valid, delete: clear
    logic                search;
    logic                reject;     // add or delete with an over-long key
    logic                longer;
    logic [LEN_W-1:0]    len;
    logic [KEY_BITS-1:0] key;        // key bits left-aligned to the top
    logic [ID_W-1:0]     id;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic clearing;
    logic lookup;
  } back_status_t;

endpackage

FILE: hw/rtl/bptt_queue.sv
// Two-entry queue of classified items between front and back.
// Depends on bptt_pkg for the item type.
module bptt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bptt_pkg::cmd_t   push_cmd,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output bptt_pkg::cmd_t   head
);

  bptt_pkg::cmd_t slot_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = slot_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: hw/rtl/bptt_front.sv
// Front end: accepts input items, decodes the kind, saturates the length
// and left-aligns the key. Depends on bptt_pkg.
module bptt_front (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bptt_pkg::KIND_W-1:0]   in_kind,
  input  logic [bptt_pkg::KEY_BITS-1:0] in_prefix_bits,
  input  logic [bptt_pkg::LEN_W-1:0]    in_prefix_length,
  input  logic                          in_longer_key,
  input  logic [bptt_pkg::ID_W-1:0]     in_entry_id,
  input  logic                          q_full,
  output logic                          push,
  output bptt_pkg::cmd_t                push_cmd
);

  logic [bptt_pkg::LEN_W-1:0] len_sat;
  logic [bptt_pkg::LEN_W-1:0] shift;
  logic                       is_write;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Saturate the length to the table depth
  always_comb begin
    if (in_prefix_length > bptt_pkg::LEN_W'(bptt_pkg::KEY_BITS)) begin
      len_sat = bptt_pkg::LEN_W'(bptt_pkg::KEY_BITS);
    end else begin
      len_sat = in_prefix_length;
    end
    shift = bptt_pkg::LEN_W'(bptt_pkg::KEY_BITS) - len_sat;
  end

  // Decode the kind into control bits
  always_comb begin
    push_cmd           = '0;
    is_write           = 1'b0;
    unique case (in_kind)
      bptt_pkg::KIND_ADD: begin
        is_write           = 1'b1;
        push_cmd.set_valid = 1'b1;
      end
      bptt_pkg::KIND_DEL: begin
        is_write           = 1'b1;
      end
      bptt_pkg::KIND_SEARCH: begin
        push_cmd.search    = 1'b1;
      end
      default: begin
        // unused kind: no change, plain answer
      end
    endcase
    push_cmd.reject   = is_write && in_longer_key;
    push_cmd.write_en = is_write && !in_longer_key;
    push_cmd.longer   = in_longer_key;
    push_cmd.len      = len_sat;
    // bits above the used length fall off the top
    push_cmd.key      = in_prefix_bits << shift;
    push_cmd.id       = in_entry_id;
  end

endmodule

FILE: hw/rtl/bptt_back.sv
// Back end: one memory bank per trie depth, reset clearing pass, lookup
// with deepest-ancestor select, and the result register. Depends on bptt_pkg.
module bptt_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  bptt_pkg::cmd_t             q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_status,
  output logic                       out_found,
  output logic [bptt_pkg::ID_W-1:0]  out_result_id,
  output bptt_pkg::back_status_t     status
);

  localparam int unsigned ND = bptt_pkg::NUM_DEPTHS;

  bptt_pkg::state_t               state_r, state_nxt;
  logic [bptt_pkg::KEY_BITS-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [bptt_pkg::LEN_W-1:0]     cur_len_r, cur_len_nxt;
  logic                           cur_longer_r, cur_longer_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_status_r, out_status_nxt;
  logic                           out_found_r, out_found_nxt;
  logic [bptt_pkg::ID_W-1:0]      out_id_r, out_id_nxt;

  logic                           clearing;
  logic                           out_free;
  logic                           wr_go;
  logic                           rd_go;
  logic [ND-1:0]                  bank_we;
  bptt_pkg::entry_t               bank_wd;
  bptt_pkg::entry_t               rd_data [ND];
  logic [ND-1:0]                  cand;
  logic [bptt_pkg::LEN_W-1:0]     hit_idx;
  logic                           hit;

  assign clearing = (state_r == bptt_pkg::ST_CLEAR);
  assign out_free = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_found     = out_found_r;
  assign out_result_id = out_id_r;

  assign status.clearing = clearing;
  assign status.lookup   = (state_r == bptt_pkg::ST_LOOKUP);

  // Bank write enables and data: clear all banks, or write the item's depth
  always_comb begin
    bank_wd = clearing ? '0 : {q_head.set_valid, q_head.id};
    for (int i = 0; i < ND; i++) begin
      bank_we[i] = clearing ||
                   (wr_go && q_head.write_en && (q_head.len == bptt_pkg::LEN_W'(i)));
    end
  end

  // Depth banks: one port each, read data registered
  for (genvar d = 0; d < ND; d++) begin : g_bank
    bptt_pkg::entry_t rd_q;
    if (d == 0) begin : g_root
      bptt_pkg::entry_t root_r;
      always_ff @(posedge clk) begin
        if (bank_we[d]) begin
          root_r <= bank_wd;
        end
        if (rd_go) begin
          rd_q <= root_r;
        end
      end
    end else begin : g_mem
      bptt_pkg::entry_t mem [2**d];
      logic [d-1:0]     addr;
      assign addr = clearing ? clr_cnt_r[d-1:0]
                             : q_head.key[bptt_pkg::KEY_BITS-1 -: d];
      always_ff @(posedge clk) begin
        if (bank_we[d]) begin
          mem[addr] <= bank_wd;
        end
        if (rd_go) begin
          rd_q <= mem[addr];
        end
      end
    end
    assign rd_data[d] = rd_q;
  end

  // Pick the deepest valid node: the exact one, or an ancestor for long keys
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ND; i++) begin
      cand[i] = rd_data[i].valid &&
                ((bptt_pkg::LEN_W'(i) == cur_len_r) ||
                 (cur_longer_r && (bptt_pkg::LEN_W'(i) < cur_len_r)));
    end
    for (int i = 0; i < ND; i++) begin
      if (cand[i]) begin
        hit_idx = bptt_pkg::LEN_W'(i);
      end
    end
    hit = |cand;
  end

  // Sequencer: clearing pass, then one item at a time
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    cur_len_nxt    = cur_len_r;
    cur_longer_nxt = cur_longer_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_id_nxt     = out_id_r;
    q_pop          = 1'b0;
    wr_go          = 1'b0;
    rd_go          = 1'b0;
    unique case (state_r)
      bptt_pkg::ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + bptt_pkg::KEY_BITS'(1);
        if (clr_cnt_r == '1) begin
          state_nxt = bptt_pkg::ST_IDLE;
        end
      end
      bptt_pkg::ST_IDLE: begin
        if (q_valid && q_head.search) begin
          // issue reads to every depth bank
          q_pop          = 1'b1;
          rd_go          = 1'b1;
          cur_len_nxt    = q_head.len;
          cur_longer_nxt = q_head.longer;
          state_nxt      = bptt_pkg::ST_LOOKUP;
        end else if (q_valid && out_free) begin
          // add, delete, rejected or unused kind: answer at once
          q_pop          = 1'b1;
          wr_go          = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = q_head.reject;
          out_found_nxt  = 1'b0;
          out_id_nxt     = '0;
        end
      end
      bptt_pkg::ST_LOOKUP: begin
        // hold the read data until the result register is free
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = 1'b0;
          out_found_nxt  = hit;
          out_id_nxt     = hit ? rd_data[hit_idx].id : '0;
          state_nxt      = bptt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bptt_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bptt_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_len_r    <= cur_len_nxt;
    cur_longer_r <= cur_longer_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_id_r     <= out_id_nxt;
  end

endmodule

FILE: hw/rtl/binary_prefix_trie_table.sv
// Top level of the binary prefix trie table: front end, item queue, back end.
// Depends on bptt_pkg, bptt_front, bptt_queue, bptt_back and the defines header.
//
//   channel | direction | handshake           | fields
//   in_     | input     | in_valid / in_stall | kind, prefix_bits, prefix_length,
//           |           |                     | longer_key, entry_id
//   out_    | output    | out_valid/out_stall | status, found, result_id
//
// Add, delete and rejected items go straight to the output register; a search
// first reads all depth banks on their single port, then does deepest-valid select.
// The back end works straight off the queue head: an item taken on the input is
// registered in the queue, a search then in the bank read registers, and each
// result in the output register. After reset a clearing pass zeroes every bank;
// items wait in the queue meanwhile, and in_stall rises once the queue is full.
// A stalled result holds in the output register while the queue keeps filling.
`include "binary_prefix_trie_table_defines.svh"

module binary_prefix_trie_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bptt_pkg::KIND_W-1:0]   in_kind,
  input  logic [bptt_pkg::KEY_BITS-1:0] in_prefix_bits,
  input  logic [bptt_pkg::LEN_W-1:0]    in_prefix_length,
  input  logic                          in_longer_key,
  input  logic [bptt_pkg::ID_W-1:0]     in_entry_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_status,
  output logic                          out_found,
  output logic [bptt_pkg::ID_W-1:0]     out_result_id
);

  logic                   q_full;
  logic                   q_push;
  bptt_pkg::cmd_t         q_push_cmd;
  logic                   q_pop;
  logic                   q_valid;
  bptt_pkg::cmd_t         q_head;
  bptt_pkg::back_status_t back_st;

  bptt_front u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_prefix_bits   (in_prefix_bits),
    .in_prefix_length (in_prefix_length),
    .in_longer_key    (in_longer_key),
    .in_entry_id      (in_entry_id),
    .q_full           (q_full),
    .push             (q_push),
    .push_cmd         (q_push_cmd)
  );

  bptt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  bptt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_found     (out_found),
    .out_result_id (out_result_id),
    .status        (back_st)
  );

  // No item leaves the queue while the banks are being cleared
  `BPTT_ASSERT_IMPL(a_no_pop_in_clear, clk, rst_n, back_st.clearing, !q_pop)
  // A search taken from the queue moves the back end into lookup
  `BPTT_ASSERT_NEXT(a_search_to_lookup, clk, rst_n, q_pop && q_head.search, back_st.lookup)
  // Only one item is in the back end during a lookup
  `BPTT_ASSERT_IMPL(a_no_pop_in_lookup, clk, rst_n, back_st.lookup, !q_pop)
  // A rejected item never reports a match
  `BPTT_ASSERT_IMPL(a_reject_no_match, clk, rst_n, out_valid && out_found, !out_status)

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the binary prefix trie table (add, delete, search).
// Depends on bptt_pkg and binary_prefix_trie_table; a built-in predictor checks every result.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned KEY_W       = bptt_pkg::KEY_BITS;
  localparam int unsigned ID_W        = bptt_pkg::ID_W;
  localparam int unsigned NODE_COUNT  = 1 << (KEY_W + 1);
  localparam int          RANDOM_OPS  = 1300;
  localparam int          POOL_SIZE   = 16;
  localparam int          IDLE_LIMIT  = 40000;
  localparam int          DRAIN_CYCLES = 20;

  // Unused operation code and result status codes
  localparam logic [bptt_pkg::KIND_W-1:0] KIND_NONE = 2'd3;
  localparam logic STAT_ACCEPTED = 1'b0;
  localparam logic STAT_REJECTED = 1'b1;

  typedef struct {
    logic [bptt_pkg::KIND_W-1:0]  kind;
    logic [KEY_W-1:0]             bits;
    logic [bptt_pkg::LEN_W-1:0]   len;
    logic                         longer;
    logic [ID_W-1:0]              id;
  } trie_op_t;

  typedef struct {
    logic            status;
    logic            found;
    logic [ID_W-1:0] id;
  } trie_result_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [bptt_pkg::KIND_W-1:0]   in_kind;
  logic [KEY_W-1:0]              in_prefix_bits;
  logic [bptt_pkg::LEN_W-1:0]    in_prefix_length;
  logic                          in_longer_key;
  logic [ID_W-1:0]               in_entry_id;
  logic                          out_valid;
  logic                          out_stall;
  logic                          out_status;
  logic                          out_found;
  logic [ID_W-1:0]               out_result_id;

  trie_op_t     ops_pending[$];
  trie_result_t results_due[$];

  // Predictor copy of the trie store
  bit              node_valid_q [0:NODE_COUNT-1];
  logic [ID_W-1:0] node_id_q    [0:NODE_COUNT-1];

  logic in_taken;
  logic out_taken;
  int   drv_wait;
  int   rx_wait;
  bit   drv_quiet;
  bit   rx_quiet;
  int   idle_cycles;
  int   n_errors;
  int   n_adds, n_dels, n_searches, n_rejects, n_exact_hits, n_fallback_hits, n_results;

  binary_prefix_trie_table u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_prefix_bits   (in_prefix_bits),
    .in_prefix_length (in_prefix_length),
    .in_longer_key    (in_longer_key),
    .in_entry_id      (in_entry_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_found        (out_found),
    .out_result_id    (out_result_id)
  );

  // Clock and initial drive of every input
  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_kind          = bptt_pkg::KIND_ADD;
    in_prefix_bits   = '0;
    in_prefix_length = '0;
    in_longer_key    = 1'b0;
    in_entry_id      = '0;
    out_stall        = 1'b0;
    forever #4 clk = ~clk;
  end

  // Work out the result of one accepted item and update the store copy
  task automatic trie_predict(input trie_op_t op);
    int unsigned  eff_len;
    int unsigned  node;
    int unsigned  anc;
    int           depth;
    trie_result_t res;
    res.status = STAT_ACCEPTED;
    res.found  = 1'b0;
    res.id     = '0;
    eff_len = (op.len > KEY_W) ? KEY_W : op.len;
    node = (1 << eff_len) | (op.bits & ((1 << eff_len) - 1));
    case (op.kind) inside
      bptt_pkg::KIND_ADD, bptt_pkg::KIND_DEL: begin
        if (op.longer) begin
          res.status = STAT_REJECTED;
          n_rejects++;
        end else if (op.kind == bptt_pkg::KIND_ADD) begin
          node_valid_q[node] = 1'b1;
          node_id_q[node]    = op.id;
          n_adds++;
        end else begin
          node_valid_q[node] = 1'b0;
          n_dels++;
        end
      end
      bptt_pkg::KIND_SEARCH: begin
        n_searches++;
        if (node_valid_q[node]) begin
          res.found = 1'b1;
          res.id    = node_id_q[node];
          n_exact_hits++;
        end else if (op.longer) begin
          // Walk up to the deepest valid proper ancestor
          depth = int'(eff_len) - 1;
          while (depth >= 0 && !res.found) begin
            anc = node >> (eff_len - depth);
            if (node_valid_q[anc]) begin
              res.found = 1'b1;
              res.id    = node_id_q[anc];
              n_fallback_hits++;
            end
            depth--;
          end
        end
      end
      default: begin
      end
    endcase
    results_due.push_back(res);
  endtask

  task automatic push_op(input logic [bptt_pkg::KIND_W-1:0] kind, input logic [KEY_W-1:0] bits,
                         input logic [bptt_pkg::LEN_W-1:0] len, input logic longer,
                         input logic [ID_W-1:0] id);
    trie_op_t op;
    op.kind   = kind;
    op.bits   = bits;
    op.len    = len;
    op.longer = longer;
    op.id     = id;
    ops_pending.push_back(op);
  endtask

  // Input driver: one item at a time, random gap before each
  always @(negedge clk) begin
    trie_op_t op;
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        // hold the stalled item
      end else begin
        if (in_taken) begin
          if ($urandom_range(0, 99) < 3) drv_quiet = !drv_quiet;
          drv_wait = drv_quiet ? 0 : $urandom_range(0, 5);
        end
        if (drv_wait > 0) begin
          drv_wait--;
          in_valid <= 1'b0;
        end else if (ops_pending.size() > 0) begin
          op = ops_pending.pop_front();
          in_kind          <= op.kind;
          in_prefix_bits   <= op.bits;
          in_prefix_length <= op.len;
          in_longer_key    <= op.longer;
          in_entry_id      <= op.id;
          in_valid         <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stall after each item taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        if ($urandom_range(0, 99) < 3) rx_quiet = !rx_quiet;
        rx_wait = rx_quiet ? 0 : $urandom_range(0, 5);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: predict on accepted input, check accepted results, watch for a hang
  always @(posedge clk) begin
    trie_op_t     op;
    trie_result_t exp_res;
    logic         acc_in;
    logic         acc_out;
    acc_in  = rst_n && in_valid && !in_stall;
    acc_out = rst_n && out_valid && !out_stall;
    in_taken  <= acc_in;
    out_taken <= acc_out;
    if (acc_in) begin
      op.kind   = in_kind;
      op.bits   = in_prefix_bits;
      op.len    = in_prefix_length;
      op.longer = in_longer_key;
      op.id     = in_entry_id;
      trie_predict(op);
    end
    if (acc_out) begin
      n_results++;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result status=%0d found=%0d id=%h", $time,
                 out_status, out_found, out_result_id);
        n_errors++;
      end else begin
        exp_res = results_due.pop_front();
        if (out_status !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.status, out_status);
          n_errors++;
        end
        if (out_found !== exp_res.found) begin
          $display("%0t: found expected %0d actual %0d", $time, exp_res.found, out_found);
          n_errors++;
        end
        if (out_result_id !== exp_res.id) begin
          $display("%0t: result_id expected %h actual %h", $time, exp_res.id, out_result_id);
          n_errors++;
        end
      end
    end
    // Count cycles with no progress; the clearing pass after reset fits well inside
    if (acc_in || acc_out || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    logic [KEY_W-1:0] pool_keys [POOL_SIZE];
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] junk;
    trie_op_t         op;
    int               pick;
    int               eff_len;
    in_taken = 1'b0;
    out_taken = 1'b0;
    drv_wait = 0;
    rx_wait = 0;
    drv_quiet = 1'b0;
    rx_quiet = 1'b0;
    idle_cycles = 0;
    n_errors = 0;
    n_adds = 0;
    n_dels = 0;
    n_searches = 0;
    n_rejects = 0;
    n_exact_hits = 0;
    n_fallback_hits = 0;
    n_results = 0;
    for (int i = 0; i < NODE_COUNT; i++) node_valid_q[i] = 1'b0;

    // Directed: empty table, extremes, fallback, rejects, saturation, unused code
    push_op(bptt_pkg::KIND_SEARCH, 13'h0000, 4'd0,  1'b0, 16'h0000);
    push_op(bptt_pkg::KIND_SEARCH, 13'h1FFF, 4'd13, 1'b1, 16'hFFFF);
    push_op(bptt_pkg::KIND_ADD,    13'h1FFF, 4'd0,  1'b0, 16'hFFFF);
    push_op(bptt_pkg::KIND_ADD,    13'h1FFF, 4'd13, 1'b0, 16'h0000);
    push_op(bptt_pkg::KIND_ADD,    13'h0000, 4'd13, 1'b0, 16'hA5A5);
    push_op(bptt_pkg::KIND_SEARCH, 13'h1FFF, 4'd13, 1'b0, 16'h1234);
    push_op(bptt_pkg::KIND_SEARCH, 13'h0000, 4'd13, 1'b1, 16'h0000);
    push_op(bptt_pkg::KIND_SEARCH, 13'h1FFE, 4'd13, 1'b0, 16'h0000);
    push_op(bptt_pkg::KIND_SEARCH, 13'h1FFE, 4'd13, 1'b1, 16'h0000);
    push_op(bptt_pkg::KIND_ADD,    13'h1FF6, 4'd5,  1'b0, 16'h1234);
    push_op(bptt_pkg::KIND_SEARCH, 13'h1600, 4'd13, 1'b1, 16'h0000);
    push_op(bptt_pkg::KIND_SEARCH, 13'h0016, 4'd5,  1'b0, 16'h0000);
    push_op(bptt_pkg::KIND_ADD,    13'h0005, 4'd3,  1'b1, 16'h7777);
    push_op(bptt_pkg::KIND_DEL,    13'h0016, 4'd5,  1'b1, 16'h0000);
    push_op(bptt_pkg::KIND_SEARCH, 13'h0005, 4'd3,  1'b0, 16'h0000);
    push_op(bptt_pkg::KIND_ADD,    13'h1FFE, 4'd15, 1'b0, 16'h5555);
    push_op(bptt_pkg::KIND_SEARCH, 13'h1FFE, 4'd14, 1'b0, 16'h0000);
    push_op(KIND_NONE,             13'h1FFF, 4'd15, 1'b1, 16'hFFFF);
    push_op(bptt_pkg::KIND_SEARCH, 13'h1FFF, 4'd0,  1'b0, 16'h0000);
    push_op(bptt_pkg::KIND_DEL,    13'h0016, 4'd5,  1'b0, 16'h0000);
    push_op(bptt_pkg::KIND_SEARCH, 13'h1600, 4'd13, 1'b1, 16'h0000);
    push_op(bptt_pkg::KIND_DEL,    13'h0000, 4'd0,  1'b0, 16'h0000);
    push_op(bptt_pkg::KIND_SEARCH, 13'h1600, 4'd13, 1'b1, 16'h0000);
    push_op(bptt_pkg::KIND_ADD,    13'h0001, 4'd1,  1'b0, 16'h8001);
    push_op(bptt_pkg::KIND_SEARCH, 13'h1FF5, 4'd4,  1'b1, 16'h0000);

    // Random: prefixes of a small key pool so searches hit and fall back often
    for (int i = 0; i < POOL_SIZE; i++) pool_keys[i] = KEY_W'($urandom);
    for (int i = 0; i < RANDOM_OPS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)      op.kind = bptt_pkg::KIND_ADD;
      else if (pick < 50) op.kind = bptt_pkg::KIND_DEL;
      else if (pick < 96) op.kind = bptt_pkg::KIND_SEARCH;
      else                op.kind = KIND_NONE;
      key = pool_keys[$urandom_range(0, POOL_SIZE - 1)];
      if ($urandom_range(0, 9) == 0) key = KEY_W'($urandom);
      if ($urandom_range(0, 9) == 0)
        op.len = bptt_pkg::LEN_W'($urandom_range(KEY_W + 1, 15));
      else if (op.kind == bptt_pkg::KIND_SEARCH && $urandom_range(0, 1) == 1)
        op.len = bptt_pkg::LEN_W'(KEY_W);
      else
        op.len = bptt_pkg::LEN_W'($urandom_range(0, KEY_W));
      eff_len = (op.len > KEY_W) ? KEY_W : op.len;
      op.bits = key >> (KEY_W - eff_len);
      // Leave junk above the used length now and then
      if ($urandom_range(0, 3) == 0) begin
        junk = KEY_W'($urandom);
        op.bits = op.bits | (junk << eff_len);
      end
      if (op.kind == bptt_pkg::KIND_SEARCH) op.longer = 1'($urandom_range(0, 1));
      else                                  op.longer = ($urandom_range(0, 9) == 0);
      op.id = ID_W'($urandom);
      ops_pending.push_back(op);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Wait for every item to go in and every result to come back
    while (ops_pending.size() != 0 || in_valid || results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("tb_top: %0d results checked; %0d adds, %0d deletes, %0d searches, %0d rejected",
             n_results, n_adds, n_dels, n_searches, n_rejects);
    $display("tb_top: searches hit %0d exact and %0d through ancestor fallback",
             n_exact_hits, n_fallback_hits);
    if (n_errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
